/* rtl/range_frame_deframer_crc_check_top_macros.svh */
// assertion macros used by the checker file
`ifndef RANGE_FRAME_DEFRAMER_CRC_CHECK_TOP_MACROS_SVH
`define RANGE_FRAME_DEFRAMER_CRC_CHECK_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define RFDC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rfdc check failed");

// next-cycle implication, checked out of reset
`define RFDC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rfdc check failed");

`endif

/* rtl/rfdc_pkg.sv */
// shared types, constants and crc function of the frame deframer
package rfdc_pkg;

  localparam int unsigned FRAME_BYTES = 20;
  localparam int unsigned CNT_W       = 5;
  localparam int unsigned ADDR_W      = 5;

  localparam logic [CNT_W-1:0] REPLY_LAST = 5'd4;   // final byte of a reply frame
  localparam logic [CNT_W-1:0] MASK_BYTE  = 5'd18;  // sensor bit mask
  localparam logic [CNT_W-1:0] CRC_BYTE   = 5'd19;  // received crc, final byte

  localparam logic [7:0] START_MEAS  = 8'h4D;  // 'M'
  localparam logic [7:0] START_REPLY = 8'h52;  // 'R'

  // configuration register indexes
  localparam logic [1:0] CFG_MIN_RANGE = 2'd0;
  localparam logic [1:0] CFG_MAX_RANGE = 2'd1;
  localparam logic [1:0] CFG_CRC_POLY  = 2'd2;

  localparam logic [14:0] MIN_RANGE_RST = 15'd50;
  localparam logic [14:0] MAX_RANGE_RST = 15'd2000;
  localparam logic [7:0]  CRC_POLY_RST  = 8'h07;

  typedef enum logic [2:0] {
    ST_RX,
    ST_CHECK,
    ST_RD_HI,
    ST_RD_LO,
    ST_EMIT,
    ST_ERR
  } state_e;

  typedef struct packed {
    logic byte_take;
    logic rd_hi;
    logic rd_lo;
    logic load_read;
    logic load_err;
  } rfdc_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic crc_ok;
    logic pend_any;
    logic pend_last;
    logic out_free;
  } rfdc_stat_t;

  // msb-first crc-8, one byte
  function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data,
                                             logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/rfdc_ctrl.sv */
// controller state machine of the frame deframer
module rfdc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  rfdc_pkg::rfdc_stat_t  stat_i,
  output rfdc_pkg::rfdc_cmd_t   cmd_o
);

  rfdc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfdc_pkg::ST_RX;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      rfdc_pkg::ST_RX: begin
        in_ready_o      = 1'b1;
        cmd_o.byte_take = in_valid_i;
        if (in_valid_i && stat_i.frame_end) begin
          state_d = rfdc_pkg::ST_CHECK;
        end
      end
      rfdc_pkg::ST_CHECK: begin
        priority if (!stat_i.crc_ok) begin
          state_d = rfdc_pkg::ST_ERR;
        end else if (stat_i.pend_any) begin
          state_d = rfdc_pkg::ST_RD_HI;
        end else begin
          state_d = rfdc_pkg::ST_RX;
        end
      end
      rfdc_pkg::ST_RD_HI: begin
        cmd_o.rd_hi = 1'b1;
        state_d     = rfdc_pkg::ST_RD_LO;
      end
      rfdc_pkg::ST_RD_LO: begin
        cmd_o.rd_lo = 1'b1;
        state_d     = rfdc_pkg::ST_EMIT;
      end
      rfdc_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_read = 1'b1;
          state_d = stat_i.pend_last ? rfdc_pkg::ST_RX : rfdc_pkg::ST_RD_HI;
        end
      end
      rfdc_pkg::ST_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.load_err = 1'b1;
          state_d        = rfdc_pkg::ST_RX;
        end
      end
      default: begin
        state_d = rfdc_pkg::ST_RX;
      end
    endcase
  end

endmodule

/* rtl/rfdc_dp.sv */
// datapath of the frame deframer: byte counter, crc, frame memory, result register
module rfdc_dp #(
  parameter int unsigned NUM_SENSORS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [14:0]           cfg_wdata_i,
  input  logic [7:0]            rx_byte_i,
  input  rfdc_pkg::rfdc_cmd_t   cmd_i,
  output rfdc_pkg::rfdc_stat_t  stat_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [2:0]            sensor_index_o,
  output logic [15:0]           range_mm_o,
  output logic [31:0]           sequence_number_o,
  output logic                  crc_error_o,
  output logic                  last_o
);

  localparam logic [7:0] SensMask = 8'((9'd1 << NUM_SENSORS) - 9'd1);

  logic [14:0] min_q, max_q;
  logic [7:0]  poly_q;

  logic [rfdc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic        meas_q, meas_d;
  logic [7:0]  crc_q, crc_d;
  logic        crc_ok_q, crc_ok_d;
  logic [7:0]  pend_q, pend_d;
  logic [31:0] seq_q, seq_d;
  logic        out_valid_q;

  logic [7:0]  store_q [rfdc_pkg::FRAME_BYTES];
  logic        wr_en;
  logic [7:0]  rdata_q, hi_q;
  logic [rfdc_pkg::ADDR_W-1:0] rd_addr;

  logic [2:0]  idx;
  logic [7:0]  pend_clr;
  logic [15:0] raw;
  logic        in_window;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= rfdc_pkg::MIN_RANGE_RST;
      max_q  <= rfdc_pkg::MAX_RANGE_RST;
      poly_q <= rfdc_pkg::CRC_POLY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rfdc_pkg::CFG_MIN_RANGE: min_q  <= cfg_wdata_i;
        rfdc_pkg::CFG_MAX_RANGE: max_q  <= cfg_wdata_i;
        rfdc_pkg::CFG_CRC_POLY:  poly_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // lowest pending sensor
  always_comb begin
    idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (pend_q[i]) begin
        idx = 3'(i);
      end
    end
  end

  assign pend_clr = pend_q & ~(8'd1 << idx);

  // byte receive path
  always_comb begin
    cnt_d    = cnt_q;
    meas_d   = meas_q;
    crc_d    = crc_q;
    crc_ok_d = crc_ok_q;
    pend_d   = pend_q;
    wr_en    = 1'b0;
    if (cmd_i.byte_take) begin
      if (cnt_q == '0) begin
        priority if (rx_byte_i == rfdc_pkg::START_MEAS) begin
          meas_d = 1'b1;
          wr_en  = 1'b1;
          crc_d  = rfdc_pkg::crc8_update(8'h00, rx_byte_i, poly_q);
          cnt_d  = 5'd1;
        end else if (rx_byte_i == rfdc_pkg::START_REPLY) begin
          meas_d = 1'b0;
          cnt_d  = 5'd1;
        end else begin
          cnt_d = '0;
        end
      end else if (meas_q) begin
        wr_en = 1'b1;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q < rfdc_pkg::CRC_BYTE) begin
          crc_d = rfdc_pkg::crc8_update(crc_q, rx_byte_i, poly_q);
        end
        if (cnt_q == rfdc_pkg::MASK_BYTE) begin
          pend_d = rx_byte_i & SensMask;
        end
        if (cnt_q == rfdc_pkg::CRC_BYTE) begin
          crc_ok_d = (crc_q == rx_byte_i);
          crc_d    = '0;
          cnt_d    = '0;
        end
      end else begin
        cnt_d = (cnt_q == rfdc_pkg::REPLY_LAST) ? '0 : cnt_q + 5'd1;
      end
    end
    if (cmd_i.load_read) begin
      pend_d = pend_clr;
    end
  end

  assign seq_d = cmd_i.load_read ? seq_q + 32'd1 : seq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      meas_q   <= 1'b0;
      crc_q    <= '0;
      crc_ok_q <= 1'b0;
      pend_q   <= '0;
      seq_q    <= '0;
    end else begin
      cnt_q    <= cnt_d;
      meas_q   <= meas_d;
      crc_q    <= crc_d;
      crc_ok_q <= crc_ok_d;
      pend_q   <= pend_d;
      seq_q    <= seq_d;
    end
  end

  // frame memory, one write and one registered read port
  assign rd_addr = cmd_i.rd_lo ? {1'b0, idx, 1'b0} + 5'd3 : {1'b0, idx, 1'b0} + 5'd2;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[cnt_q] <= rx_byte_i;
    end
    if (cmd_i.rd_hi || cmd_i.rd_lo) begin
      rdata_q <= store_q[rd_addr];
    end
    if (cmd_i.rd_lo) begin
      hi_q <= rdata_q;
    end
  end

  // window check, negative raw values fall below it
  assign raw       = {hi_q, rdata_q};
  assign in_window = !raw[15] && (raw[14:0] > min_q) && (raw[14:0] < max_q);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_read || cmd_i.load_err) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_read) begin
      sensor_index_o    <= idx;
      range_mm_o        <= in_window ? raw : 16'hFFFF;
      sequence_number_o <= seq_q;
      crc_error_o       <= 1'b0;
      last_o            <= (pend_clr == '0);
    end else if (cmd_i.load_err) begin
      sensor_index_o    <= '0;
      range_mm_o        <= '0;
      sequence_number_o <= '0;
      crc_error_o       <= 1'b1;
      last_o            <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign stat_o.frame_end = meas_q && (cnt_q == rfdc_pkg::CRC_BYTE);
  assign stat_o.crc_ok    = crc_ok_q;
  assign stat_o.pend_any  = (pend_q != '0);
  assign stat_o.pend_last = (pend_clr == '0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

/* rtl/range_frame_deframer_crc_check_top.sv */
// top level of the serial frame deframer with crc-8 check
//
//   channel   dir  handshake                     payload
//   s_axis    in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte
//   m_axis    out  m_axis_tvalid/m_axis_tready   tdata sensor/range/sequence, tuser crc
//                                                error, tlast end of frame results
//   cfg       in   cfg_we_i (no handshake)       cfg_idx_i, cfg_wdata_i
//
// bytes are taken one per cycle while a frame is being received
// after the final byte of a measurement frame the input is held off for the crc
//   check, then for the readout of each reported sensor (two frame memory reads
//   through its single read port plus the result load), or for the crc error result
// a stalled output beat stretches that time; the result register frees the output
// reset is asynchronous active low and clears counters, crc, state and valid flags
module range_frame_deframer_crc_check_top #(
  parameter int unsigned NUM_SENSORS = 8  // sensors reported, 1 to 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_wdata_i,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [2:0] sensor_index, [18:3] range_mm,
                                      // [50:19] sequence_number, [55:51] zero
  output logic        m_axis_tuser,   // [0] crc_error
  output logic        m_axis_tlast    // last result of the frame
);

  rfdc_pkg::rfdc_cmd_t  cmd;
  rfdc_pkg::rfdc_stat_t stat;

  logic [2:0]  sensor_index;
  logic [15:0] range_mm;
  logic [31:0] sequence_number;

  // sequencing: receive, crc check, per-sensor readout
  rfdc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // frame storage, crc and result register
  rfdc_dp #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .rx_byte_i         (s_axis_tdata),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .sensor_index_o    (sensor_index),
    .range_mm_o        (range_mm),
    .sequence_number_o (sequence_number),
    .crc_error_o       (m_axis_tuser),
    .last_o            (m_axis_tlast)
  );

  // pack result fields, lowest field first
  assign m_axis_tdata = {5'd0, sequence_number, range_mm, sensor_index};

endmodule

/* rtl/rfdc_chk.sv */
// port-level checker of the frame deframer and its bind
`include "range_frame_deframer_crc_check_top_macros.svh"

module rfdc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a crc error beat carries no reading and closes the frame
  `RFDC_ASSERT_NOW(a_err_beat, m_axis_tvalid && m_axis_tuser, (m_axis_tdata == '0) && m_axis_tlast)

  // a negative range is only ever the out-of-window marker
  `RFDC_ASSERT_NOW(a_range_neg, m_axis_tvalid && m_axis_tdata[18], m_axis_tdata[18:3] == 16'hFFFF)

  // byte input is held off while a result that is not the last of its frame waits to leave
  `RFDC_ASSERT_NOW(a_in_hold, m_axis_tvalid && !m_axis_tready && !m_axis_tlast, !s_axis_tready)

  // a stalled result beat holds
  `RFDC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // upper pad bits stay clear
  `RFDC_ASSERT_NOW(a_pad_zero, m_axis_tvalid && s_axis_tvalid, m_axis_tdata[55:51] == '0)

endmodule

bind range_frame_deframer_crc_check_top rfdc_chk u_chk (.*);
